@@ sv/tfr_pkg.sv @@
package tfr_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ID_W     = 11;
  localparam int unsigned TOUT_W   = 16;
  localparam int unsigned CNT_W    = 4;
  localparam int unsigned PKT_DATA = 9;
  localparam int unsigned TDATA_W  = 80;

  localparam logic [CNT_W-1:0]  PKT_DATA_CNT = 4'd9;
  localparam logic [CNT_W-1:0]  PKT_LAST_CNT = 4'd9;   // count before the tenth byte
  localparam logic [ID_W-1:0]   ID_OFFSET    = 11'h100;
  localparam logic [15:0]       VOLT_MIN     = 16'd1000;
  localparam logic [15:0]       VOLT_MAX     = 16'd4060;
  // floor(x/3) == (x*683)>>11 for x below 2048
  localparam logic [9:0]        VOLT_RECIP   = 10'd683;

  localparam logic [ID_W-1:0]   NODE_ID_RST  = 11'd518;
  localparam logic [TOUT_W-1:0] TIMEOUT_RST  = 16'd10;

  typedef enum logic [0:0] {
    CFG_NODE_ID = 1'b0,
    CFG_TIMEOUT = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    FUNC_BYTE = 1'b0,
    FUNC_TICK = 1'b1
  } item_func_e;

  typedef logic [PKT_DATA-1:0][BYTE_W-1:0] pkt_bytes_t;

  // first member lands in the top bits, so the list runs backward
  typedef struct packed {
    logic [BYTE_W-1:0] erpm_low;
    logic [BYTE_W-1:0] erpm_high;
    logic [BYTE_W-1:0] energy_low;
    logic [BYTE_W-1:0] energy_high;
    logic [BYTE_W-1:0] current_low;
    logic [BYTE_W-1:0] current_high;
    logic [BYTE_W-1:0] voltage_code;
    logic [BYTE_W-1:0] temperature;
    logic [ID_W-1:0]   frame_id;
  } frame_t;

endpackage

@@ sv/tfr_frame_pack.sv @@
module tfr_frame_pack import tfr_pkg::*; (
  input  logic [ID_W-1:0] node_id_i,
  input  pkt_bytes_t      bytes_i,
  output frame_t          frame_o
);

  logic [15:0] volt;
  logic [15:0] volt_diff;
  logic [9:0]  volt_quarter;
  logic [19:0] volt_prod;
  logic [7:0]  volt_code;

  always_comb begin
    volt         = {bytes_i[1], bytes_i[2]};
    volt_diff    = volt - VOLT_MIN;
    // divide by 12 as divide by 4 then by 3
    volt_quarter = volt_diff[11:2];
    volt_prod    = 20'(volt_quarter) * 20'(VOLT_RECIP);
    if (volt <= VOLT_MIN) begin
      volt_code = 8'd0;
    end else if (volt >= VOLT_MAX) begin
      volt_code = 8'hFF;
    end else begin
      volt_code = volt_prod[18:11];
    end
  end

  always_comb begin
    frame_o.frame_id     = node_id_i + ID_OFFSET;
    frame_o.temperature  = bytes_i[0];
    frame_o.voltage_code = volt_code;
    frame_o.current_high = bytes_i[3];
    frame_o.current_low  = bytes_i[4];
    frame_o.energy_high  = bytes_i[5];
    frame_o.energy_low   = bytes_i[6];
    frame_o.erpm_high    = bytes_i[7];
    frame_o.erpm_low     = bytes_i[8];
  end

endmodule

@@ sv/telemetry_frame_repacker_unit.sv @@
// Telemetry frame repacker.
// Slave stream: each word is a received serial byte (tuser 0, byte in tdata)
// or a millisecond tick (tuser 1). Bytes build a packet of up to ten; the
// first byte starts a tick timer. A packet closes on its tenth byte or when
// the timer reaches timeout_ticks; with at least nine bytes one frame word
// goes out on the master stream, otherwise the bytes are dropped.
// Config: cfg_we_i writes cfg_wdata_i to register cfg_addr_i
// (0 node_id, 1 timeout_ticks) at the clock edge; write only while idle.
// A taken word sits in the input register until the output register is
// free; it is then processed, and a frame that it closes is registered
// in the output register and shows on m_axis_tvalid.
// One word per cycle is accepted while the receiver is not stalling,
// set by the single update step between the input and output registers.
// When the receiver stalls, the output word holds, the input register
// fills and s_axis_tready drops after one more word.
// Reset clears the byte count, timer and both valid flags and restores
// node_id 518 and timeout_ticks 10.
module telemetry_frame_repacker_unit import tfr_pkg::*; #(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,   // rx_byte
  input  logic               s_axis_tuser,   // func
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // frame_id, temperature, voltage_code, current_high, current_low,
  // energy_high, energy_low, erpm_high, erpm_low, zero fill
  output logic [TDATA_W-1:0] m_axis_tdata,
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_addr_i,
  input  logic [TOUT_W-1:0]  cfg_wdata_i
);

  localparam int unsigned CMP_W = (TIMER_BITS > TOUT_W) ? TIMER_BITS : TOUT_W;
  localparam logic [TIMER_BITS-1:0] TIMER_MAX = '1;

  logic [ID_W-1:0]       node_id_q;
  logic [TOUT_W-1:0]     timeout_q;

  logic                  in_vld_q;
  logic                  in_func_q;
  logic [BYTE_W-1:0]     in_byte_q;

  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [TIMER_BITS-1:0] elapsed_q, elapsed_d;
  logic                  active_q, active_d;
  pkt_bytes_t            bytes_q;

  logic                  out_vld_q, out_vld_d;
  frame_t                frame_q;
  frame_t                frame_c;

  logic                  proc_go;
  logic                  emit;
  logic [TIMER_BITS-1:0] elapsed_inc;
  logic [CMP_W-1:0]      elapsed_ext;
  logic [CMP_W-1:0]      timeout_ext;

  assign proc_go       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || proc_go;
  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(TDATA_W - $bits(frame_t))'(0), frame_q};

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q <= NODE_ID_RST;
      timeout_q <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_NODE_ID: node_id_q <= cfg_wdata_i[ID_W-1:0];
        CFG_TIMEOUT: timeout_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_func_q <= s_axis_tuser;
      in_byte_q <= s_axis_tdata;
    end
  end

  // packet state update
  always_comb begin
    elapsed_inc = (elapsed_q != TIMER_MAX) ? elapsed_q + 1'b1 : elapsed_q;
    elapsed_ext = CMP_W'(elapsed_inc);
    timeout_ext = CMP_W'(timeout_q);
    cnt_d       = cnt_q;
    elapsed_d   = elapsed_q;
    active_d    = active_q;
    emit        = 1'b0;
    if (proc_go) begin
      case (item_func_e'(in_func_q))
        FUNC_BYTE: begin
          if (cnt_q == PKT_LAST_CNT) begin
            emit      = 1'b1;
            cnt_d     = '0;
            active_d  = 1'b0;
            elapsed_d = '0;
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (cnt_q == '0) begin
              active_d  = 1'b1;
              elapsed_d = '0;
            end
          end
        end
        FUNC_TICK: begin
          if (active_q) begin
            if (elapsed_ext >= timeout_ext || elapsed_inc == TIMER_MAX) begin
              emit      = (cnt_q >= PKT_DATA_CNT);
              cnt_d     = '0;
              active_d  = 1'b0;
              elapsed_d = '0;
            end else begin
              elapsed_d = elapsed_inc;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= '0;
      elapsed_q <= '0;
      active_q  <= 1'b0;
    end else begin
      cnt_q     <= cnt_d;
      elapsed_q <= elapsed_d;
      active_q  <= active_d;
    end
  end

  // packet byte store, only entries below nine are kept
  always_ff @(posedge clk_i) begin
    if (proc_go && in_func_q == FUNC_BYTE && cnt_q < PKT_DATA_CNT) begin
      bytes_q[cnt_q] <= in_byte_q;
    end
  end

  tfr_frame_pack u_frame_pack (
    .node_id_i (node_id_q),
    .bytes_i   (bytes_q),
    .frame_o   (frame_c)
  );

  // output register
  always_comb begin
    if (proc_go) begin
      out_vld_d = emit;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      frame_q <= frame_c;
    end
  end

`ifndef ASSERT_OFF
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= PKT_LAST_CNT)
    else $error("byte count out of range");

  a_idle_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (cnt_q == '0 && elapsed_q == '0))
    else $error("idle with packet state left over");

  a_active_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> cnt_q != '0)
    else $error("timer running with empty packet");

  a_emit_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |-> cnt_q == PKT_DATA_CNT)
    else $error("frame built from a short packet");
`endif

endmodule
